@@ rtl/sgi_pkg.sv @@
package sgi_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int OUT_BITS       = 24;
   localparam int RSP_BITS       = 56;

   typedef struct packed {
      logic valid;
      logic hit;
      logic col;
      logic pv;
      logic neg_x;
      logic neg_y;
   } sgi_flags_type;

endpackage

@@ rtl/sgi_prep.sv @@
module sgi_prep #(
   parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = sgi_pkg::FRAC_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        adv,
   input  logic                                        in_valid,
   input  logic [8*COORD_BITS-1:0]                     in_data,
   output sgi_pkg::sgi_flags_type                      out_flags,
   output logic [3*COORD_BITS+FRAC_BITS+2:0]           out_rem_x,
   output logic [3*COORD_BITS+FRAC_BITS+2:0]           out_rem_y,
   output logic [2*COORD_BITS+1:0]                     out_den,
   output logic signed [COORD_BITS-1:0]                out_base_x,
   output logic signed [COORD_BITS-1:0]                out_base_y
);
   import sgi_pkg::*;

   localparam int N  = COORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int MW = 2*N+2;
   localparam int CM = N+1;
   localparam int LH = (MW+1)/2;
   localparam int HH = MW-LH;
   localparam int DW = CM+MW+F;

   typedef logic signed [N-1:0]  crd_type;
   typedef logic signed [N:0]    dif_type;
   typedef logic signed [2*N+1:0] prd_type;
   typedef logic signed [2*N+2:0] crs_type;

   function automatic logic lex_less(input crd_type px, input crd_type py,
                                     input crd_type qx, input crd_type qy);
      return (px != qx) ? (px < qx) : (py < qy);
   endfunction

   function automatic dif_type sub(input crd_type p, input crd_type q);
      return {p[N-1], p} - {q[N-1], q};
   endfunction

   function automatic crs_type crs(input prd_type p, input prd_type q);
      return {p[2*N+1], p} - {q[2*N+1], q};
   endfunction

   function automatic logic [MW-1:0] mag(input crs_type v);
      crs_type t;
      t = v[2*N+2] ? -v : v;
      return t[MW-1:0];
   endfunction

   // stage 1: endpoints and differences
   crd_type ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
   assign ax0 = in_data[0*N +: N];
   assign ay0 = in_data[1*N +: N];
   assign ax1 = in_data[2*N +: N];
   assign ay1 = in_data[3*N +: N];
   assign bx0 = in_data[4*N +: N];
   assign by0 = in_data[5*N +: N];
   assign bx1 = in_data[6*N +: N];
   assign by1 = in_data[7*N +: N];

   logic    s1_v_ff;
   crd_type s1_ax0_ff, s1_ay0_ff, s1_ax1_ff, s1_ay1_ff;
   crd_type s1_bx0_ff, s1_by0_ff, s1_bx1_ff, s1_by1_ff;
   dif_type s1_cx_ff, s1_cy_ff, s1_dx_ff, s1_dy_ff, s1_ex_ff, s1_ey_ff;
   dif_type s1_fx_ff, s1_fy_ff, s1_gx_ff, s1_gy_ff, s1_hx_ff, s1_hy_ff;
   dif_type s1_cx_in, s1_cy_in, s1_dx_in, s1_dy_in, s1_ex_in, s1_ey_in;
   dif_type s1_fx_in, s1_fy_in, s1_gx_in, s1_gy_in, s1_hx_in, s1_hy_in;

   assign s1_cx_in = sub(ax1, ax0);
   assign s1_cy_in = sub(ay1, ay0);
   assign s1_dx_in = sub(bx1, bx0);
   assign s1_dy_in = sub(by1, by0);
   assign s1_ex_in = sub(bx0, ax0);
   assign s1_ey_in = sub(by0, ay0);
   assign s1_fx_in = sub(bx1, ax0);
   assign s1_fy_in = sub(by1, ay0);
   assign s1_gx_in = sub(ax0, bx0);
   assign s1_gy_in = sub(ay0, by0);
   assign s1_hx_in = sub(ax1, bx0);
   assign s1_hy_in = sub(ay1, by0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ax0_ff <= ax0; s1_ay0_ff <= ay0; s1_ax1_ff <= ax1; s1_ay1_ff <= ay1;
         s1_bx0_ff <= bx0; s1_by0_ff <= by0; s1_bx1_ff <= bx1; s1_by1_ff <= by1;
         s1_cx_ff <= s1_cx_in; s1_cy_ff <= s1_cy_in;
         s1_dx_ff <= s1_dx_in; s1_dy_ff <= s1_dy_in;
         s1_ex_ff <= s1_ex_in; s1_ey_ff <= s1_ey_in;
         s1_fx_ff <= s1_fx_in; s1_fy_ff <= s1_fy_in;
         s1_gx_ff <= s1_gx_in; s1_gy_ff <= s1_gy_in;
         s1_hx_ff <= s1_hx_in; s1_hy_ff <= s1_hy_in;
      end
   end

   // stage 2: cross product terms and collinear range overlap
   logic    s2_v_ff;
   prd_type s2_p_ff [12];
   prd_type s2_p_in [12];
   logic    s2_ovl_ff, s2_ovl_in;
   dif_type s2_cx_ff, s2_cy_ff;
   crd_type s2_ax0_ff, s2_ay0_ff;

   assign s2_p_in[0]  = s1_cx_ff * s1_ey_ff;
   assign s2_p_in[1]  = s1_cy_ff * s1_ex_ff;
   assign s2_p_in[2]  = s1_cx_ff * s1_fy_ff;
   assign s2_p_in[3]  = s1_cy_ff * s1_fx_ff;
   assign s2_p_in[4]  = s1_dx_ff * s1_gy_ff;
   assign s2_p_in[5]  = s1_dy_ff * s1_gx_ff;
   assign s2_p_in[6]  = s1_dx_ff * s1_hy_ff;
   assign s2_p_in[7]  = s1_dy_ff * s1_hx_ff;
   assign s2_p_in[8]  = s1_cx_ff * s1_dy_ff;
   assign s2_p_in[9]  = s1_cy_ff * s1_dx_ff;
   assign s2_p_in[10] = s1_ex_ff * s1_dy_ff;
   assign s2_p_in[11] = s1_ey_ff * s1_dx_ff;

   always_comb begin
      crd_type lx0, ly0, lx1, ly1, sx0, sy0, sx1, sy1;
      if (lex_less(s1_ax1_ff, s1_ay1_ff, s1_ax0_ff, s1_ay0_ff)) begin
         lx0 = s1_ax1_ff; ly0 = s1_ay1_ff; lx1 = s1_ax0_ff; ly1 = s1_ay0_ff;
      end else begin
         lx0 = s1_ax0_ff; ly0 = s1_ay0_ff; lx1 = s1_ax1_ff; ly1 = s1_ay1_ff;
      end
      if (lex_less(s1_bx1_ff, s1_by1_ff, s1_bx0_ff, s1_by0_ff)) begin
         sx0 = s1_bx1_ff; sy0 = s1_by1_ff; sx1 = s1_bx0_ff; sy1 = s1_by0_ff;
      end else begin
         sx0 = s1_bx0_ff; sy0 = s1_by0_ff; sx1 = s1_bx1_ff; sy1 = s1_by1_ff;
      end
      s2_ovl_in = !(lex_less(lx1, ly1, sx0, sy0) || lex_less(sx1, sy1, lx0, ly0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_p_ff   <= s2_p_in;
         s2_ovl_ff <= s2_ovl_in;
         s2_cx_ff  <= s1_cx_ff;
         s2_cy_ff  <= s1_cy_ff;
         s2_ax0_ff <= s1_ax0_ff;
         s2_ay0_ff <= s1_ay0_ff;
      end
   end

   // stage 3: cross products, decision, magnitudes and signs
   crs_type r1, r2, r3, r4, den_s, num_s;
   logic    straddle;
   sgi_flags_type s3_fl_ff, s3_fl_in;
   logic [CM-1:0] s3_cmx_ff, s3_cmy_ff, s3_cmx_in, s3_cmy_in;
   logic [MW-1:0] s3_num_ff, s3_den_ff;
   crd_type s3_ax0_ff, s3_ay0_ff;

   assign r1    = crs(s2_p_ff[0], s2_p_ff[1]);
   assign r2    = crs(s2_p_ff[2], s2_p_ff[3]);
   assign r3    = crs(s2_p_ff[4], s2_p_ff[5]);
   assign r4    = crs(s2_p_ff[6], s2_p_ff[7]);
   assign den_s = crs(s2_p_ff[8], s2_p_ff[9]);
   assign num_s = crs(s2_p_ff[10], s2_p_ff[11]);

   assign straddle = !((r1 > 0 && r2 > 0) || (r1 < 0 && r2 < 0)) &&
                     !((r3 > 0 && r4 > 0) || (r3 < 0 && r4 < 0));
   assign s3_cmx_in = s2_cx_ff[N] ? -s2_cx_ff : s2_cx_ff;
   assign s3_cmy_in = s2_cy_ff[N] ? -s2_cy_ff : s2_cy_ff;

   always_comb begin
      s3_fl_in.valid = s2_v_ff;
      s3_fl_in.col   = (r1 == 0) && (r2 == 0);
      s3_fl_in.hit   = s3_fl_in.col ? s2_ovl_ff : straddle;
      s3_fl_in.pv    = s3_fl_in.hit && !s3_fl_in.col && (den_s != 0);
      s3_fl_in.neg_x = s2_cx_ff[N] ^ num_s[2*N+2] ^ den_s[2*N+2];
      s3_fl_in.neg_y = s2_cy_ff[N] ^ num_s[2*N+2] ^ den_s[2*N+2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_fl_ff.valid <= 1'b0;
      end else if (adv) begin
         s3_fl_ff <= s3_fl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_cmx_ff <= s3_cmx_in;
         s3_cmy_ff <= s3_cmy_in;
         s3_num_ff <= mag(num_s);
         s3_den_ff <= mag(den_s);
         s3_ax0_ff <= s2_ax0_ff;
         s3_ay0_ff <= s2_ay0_ff;
      end
   end

   // stage 4: split products |c| * |num|
   sgi_flags_type s4_fl_ff;
   logic [CM+LH-1:0] s4_xl_ff, s4_yl_ff;
   logic [CM+HH-1:0] s4_xh_ff, s4_yh_ff;
   logic [MW-1:0]    s4_den_ff;
   crd_type          s4_ax0_ff, s4_ay0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_fl_ff.valid <= 1'b0;
      end else if (adv) begin
         s4_fl_ff <= s3_fl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_xl_ff  <= (CM+LH)'(s3_cmx_ff) * (CM+LH)'(s3_num_ff[LH-1:0]);
         s4_yl_ff  <= (CM+LH)'(s3_cmy_ff) * (CM+LH)'(s3_num_ff[LH-1:0]);
         s4_xh_ff  <= (CM+HH)'(s3_cmx_ff) * (CM+HH)'(s3_num_ff[MW-1:LH]);
         s4_yh_ff  <= (CM+HH)'(s3_cmy_ff) * (CM+HH)'(s3_num_ff[MW-1:LH]);
         s4_den_ff <= s3_den_ff;
         s4_ax0_ff <= s3_ax0_ff;
         s4_ay0_ff <= s3_ay0_ff;
      end
   end

   // stage 5: dividends, scaled by the fraction
   logic [DW-1:0] s5_rx_in, s5_ry_in;

   assign s5_rx_in = ((DW'(s4_xh_ff) << LH) + DW'(s4_xl_ff)) << F;
   assign s5_ry_in = ((DW'(s4_yh_ff) << LH) + DW'(s4_yl_ff)) << F;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_flags.valid <= 1'b0;
      end else if (adv) begin
         out_flags <= s4_fl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_rem_x  <= s5_rx_in;
         out_rem_y  <= s5_ry_in;
         out_den    <= s4_den_ff;
         out_base_x <= s4_ax0_ff;
         out_base_y <= s4_ay0_ff;
      end
   end

endmodule

@@ rtl/sgi_div_cell.sv @@
module sgi_div_cell #(
   parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = sgi_pkg::FRAC_BITS_DEF,
   parameter int SHIFT      = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  sgi_pkg::sgi_flags_type               in_flags,
   input  logic [3*COORD_BITS+FRAC_BITS+2:0]    in_rem_x,
   input  logic [3*COORD_BITS+FRAC_BITS+2:0]    in_rem_y,
   input  logic [2*COORD_BITS+1:0]              in_den,
   input  logic [COORD_BITS+FRAC_BITS:0]        in_q_x,
   input  logic [COORD_BITS+FRAC_BITS:0]        in_q_y,
   input  logic signed [COORD_BITS-1:0]         in_base_x,
   input  logic signed [COORD_BITS-1:0]         in_base_y,
   output sgi_pkg::sgi_flags_type               out_flags,
   output logic [3*COORD_BITS+FRAC_BITS+2:0]    out_rem_x,
   output logic [3*COORD_BITS+FRAC_BITS+2:0]    out_rem_y,
   output logic [2*COORD_BITS+1:0]              out_den,
   output logic [COORD_BITS+FRAC_BITS:0]        out_q_x,
   output logic [COORD_BITS+FRAC_BITS:0]        out_q_y,
   output logic signed [COORD_BITS-1:0]         out_base_x,
   output logic signed [COORD_BITS-1:0]         out_base_y
);
   import sgi_pkg::*;

   localparam int DW = 3*COORD_BITS+FRAC_BITS+3;
   localparam int MW = 2*COORD_BITS+2;

   logic [DW-1:0] dsh;
   logic          fit_x, fit_y;
   logic [DW-1:0] rem_x_in, rem_y_in;
   logic [COORD_BITS+FRAC_BITS:0] q_x_in, q_y_in;

   assign dsh   = {{(DW-MW){1'b0}}, in_den} << SHIFT;
   assign fit_x = in_rem_x >= dsh;
   assign fit_y = in_rem_y >= dsh;

   // subtract the shifted divisor where it fits and set this quotient bit
   always_comb begin
      rem_x_in = fit_x ? in_rem_x - dsh : in_rem_x;
      rem_y_in = fit_y ? in_rem_y - dsh : in_rem_y;
      q_x_in = in_q_x;
      q_y_in = in_q_y;
      q_x_in[SHIFT] = fit_x;
      q_y_in[SHIFT] = fit_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_flags.valid <= 1'b0;
      end else if (adv) begin
         out_flags <= in_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_rem_x  <= rem_x_in;
         out_rem_y  <= rem_y_in;
         out_den    <= in_den;
         out_q_x    <= q_x_in;
         out_q_y    <= q_y_in;
         out_base_x <= in_base_x;
         out_base_y <= in_base_y;
      end
   end

endmodule

@@ rtl/segment_intersection_core.sv @@
// Stages: five setup stages, one divider cell per quotient bit, one output register.
// Throughput: one request per cycle; the whole pipe holds while a result waits.
// Reset: synchronous, active high; clears every stage valid bit and the output valid.
module segment_intersection_core #(
   parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = sgi_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
   input  logic [8*COORD_BITS-1:0]       req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // intersects, collinear, point_valid, cross_x[23:0], cross_y[23:0], zero pad
   output logic [sgi_pkg::RSP_BITS-1:0]  rsp_tdata
);
   import sgi_pkg::*;

   localparam int N  = COORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int DW = 3*N+F+3;
   localparam int MW = 2*N+2;
   localparam int QB = N+F+1;
   localparam int SW = N+F+3;
   localparam int RW = (SW > OUT_BITS) ? SW : OUT_BITS;

   logic adv;
   logic rsp_v_ff;
   logic [RSP_BITS-1:0] rsp_d_ff, rsp_d_in;

   assign adv        = !rsp_v_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

   sgi_flags_type       fl_c   [QB+1];
   logic [DW-1:0]       rx_c   [QB+1];
   logic [DW-1:0]       ry_c   [QB+1];
   logic [MW-1:0]       den_c  [QB+1];
   logic [QB-1:0]       qx_c   [QB+1];
   logic [QB-1:0]       qy_c   [QB+1];
   logic signed [N-1:0] bx_c   [QB+1];
   logic signed [N-1:0] by_c   [QB+1];

   sgi_prep #(.COORD_BITS(N), .FRAC_BITS(F)) u_prep (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (req_tvalid),
      .in_data    (req_tdata),
      .out_flags  (fl_c[0]),
      .out_rem_x  (rx_c[0]),
      .out_rem_y  (ry_c[0]),
      .out_den    (den_c[0]),
      .out_base_x (bx_c[0]),
      .out_base_y (by_c[0])
   );

   assign qx_c[0] = '0;
   assign qy_c[0] = '0;

   // most significant quotient bit first
   for (genvar i = 0; i < QB; i++) begin : g_cell
      sgi_div_cell #(.COORD_BITS(N), .FRAC_BITS(F), .SHIFT(QB-1-i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .in_flags   (fl_c[i]),
         .in_rem_x   (rx_c[i]),
         .in_rem_y   (ry_c[i]),
         .in_den     (den_c[i]),
         .in_q_x     (qx_c[i]),
         .in_q_y     (qy_c[i]),
         .in_base_x  (bx_c[i]),
         .in_base_y  (by_c[i]),
         .out_flags  (fl_c[i+1]),
         .out_rem_x  (rx_c[i+1]),
         .out_rem_y  (ry_c[i+1]),
         .out_den    (den_c[i+1]),
         .out_q_x    (qx_c[i+1]),
         .out_q_y    (qy_c[i+1]),
         .out_base_x (bx_c[i+1]),
         .out_base_y (by_c[i+1])
      );
   end

   sgi_flags_type fl_e;
   logic signed [RW-1:0] qsx, qsy, bsx, bsy, px, py;

   assign fl_e = fl_c[QB];
   assign qsx  = {{(RW-QB){1'b0}}, qx_c[QB]};
   assign qsy  = {{(RW-QB){1'b0}}, qy_c[QB]};
   assign bsx  = {{(RW-N){bx_c[QB][N-1]}}, bx_c[QB]} <<< F;
   assign bsy  = {{(RW-N){by_c[QB][N-1]}}, by_c[QB]} <<< F;
   assign px   = fl_e.pv ? bsx + (fl_e.neg_x ? -qsx : qsx) : '0;
   assign py   = fl_e.pv ? bsy + (fl_e.neg_y ? -qsy : qsy) : '0;

   always_comb begin
      rsp_d_in = '0;
      rsp_d_in[0] = fl_e.hit;
      rsp_d_in[1] = fl_e.col;
      rsp_d_in[2] = fl_e.pv;
      rsp_d_in[3 +: OUT_BITS] = px[OUT_BITS-1:0];
      rsp_d_in[3+OUT_BITS +: OUT_BITS] = py[OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= fl_e.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_d_ff <= rsp_d_in;
      end
   end

endmodule
